// File: design/prefix_code_table_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prefix code table decoder
// Shared property wrappers; clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_TABLE_DECODER_ASSERT_SVH
`define PREFIX_CODE_TABLE_DECODER_ASSERT_SVH

// Same-cycle implication
`define PCD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pcd assertion failed");

// Next-cycle implication
`define PCD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pcd assertion failed");

`endif

// File: design/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Widths, request and status codes and shared structs of the decoder.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int IDX_W      = 6;
    localparam int CODE_W     = 16;
    localparam int LEN_W      = 5;
    localparam int SYM_W      = 8;
    localparam int KEY_LEN_W  = 6;   // holds partial lengths up to 63
    localparam int GROUP_SIZE = 8;   // cells per priority segment

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // result status
    localparam logic STAT_SYMBOL   = 1'b0;
    localparam logic STAT_OVERFLOW = 1'b1;

    // one table slot
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic [SYM_W-1:0]  symbol;
    } t_slot;

    // search key broadcast to every cell
    typedef struct packed {
        logic [KEY_LEN_W-1:0] length;
        logic [CODE_W-1:0]    mask;
        logic [CODE_W-1:0]    code;
        logic                 hi_ok;   // partial code bits above CODE_W are zero
    } t_key;

    // priority link between neighboring cells
    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] symbol;
    } t_link;

endpackage

// File: design/pcd_if.sv
// ----------------------------------------------------------------------------
// pcd request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pcd_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [pcd_pkg::IDX_W-1:0]     entry_index;
    logic [pcd_pkg::CODE_W-1:0]    entry_code;
    logic [pcd_pkg::LEN_W-1:0]     entry_length;
    logic [pcd_pkg::SYM_W-1:0]     entry_symbol;
    logic                          entry_valid;
    logic                          code_bit;

    modport source (output valid, req_type, entry_index, entry_code, entry_length,
                    entry_symbol, entry_valid, code_bit, input ready);
    modport sink   (input valid, req_type, entry_index, entry_code, entry_length,
                    entry_symbol, entry_valid, code_bit, output ready);
endinterface

interface pcd_res_if;
    logic                       valid;
    logic                       ready;
    logic [pcd_pkg::SYM_W-1:0]  symbol;
    logic                       status;

    modport source (output valid, symbol, status, input ready);
    modport sink   (input valid, symbol, status, output ready);
endinterface

// File: design/pcd_cell.sv
// ----------------------------------------------------------------------------
// pcd_cell
// One table slot: holds the entry, matches it against the key and passes
// the lowest-index hit on to its higher-index neighbor.
// ----------------------------------------------------------------------------
module pcd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  pcd_pkg::t_slot i_wr,
    input  pcd_pkg::t_key  i_key,
    input  pcd_pkg::t_link i_link,
    output pcd_pkg::t_link o_link
);

    logic                       r_valid;
    logic [pcd_pkg::CODE_W-1:0] r_code;
    logic [pcd_pkg::LEN_W-1:0]  r_length;
    logic [pcd_pkg::SYM_W-1:0]  r_symbol;
    logic                       hit;

    // valid flag, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_we) begin
            r_valid <= i_wr.valid;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_code   <= i_wr.code;
            r_length <= i_wr.length;
            r_symbol <= i_wr.symbol;
        end
    end

    // exact length and masked code compare
    assign hit = r_valid && i_key.hi_ok
              && ({1'b0, r_length} == i_key.length)
              && ((r_code & i_key.mask) == i_key.code);

    // lower index keeps priority
    always_comb begin
        if (i_link.found) begin
            o_link = i_link;
        end else begin
            o_link.found  = hit;
            o_link.symbol = r_symbol;
        end
    end

endmodule

// File: design/pcd_group.sv
// ----------------------------------------------------------------------------
// pcd_group
// A segment of chained cells; registers the segment's winning symbol.
// ----------------------------------------------------------------------------
module pcd_group #(
    parameter int BASE  = 0,
    parameter int CELLS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [pcd_pkg::IDX_W-1:0] i_wr_index,
    input  pcd_pkg::t_slot            i_wr,
    input  pcd_pkg::t_key             i_key,
    input  logic                      i_cap,
    output logic                      o_found,
    output pcd_pkg::t_link            o_win
);

    pcd_pkg::t_link link [CELLS+1];
    pcd_pkg::t_link r_win;

    assign link[0] = '0;

    // cell row
    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        logic cell_we;
        assign cell_we = i_we && (32'(i_wr_index) == 32'(BASE + c));

        pcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (cell_we),
            .i_wr    (i_wr),
            .i_key   (i_key),
            .i_link  (link[c]),
            .o_link  (link[c+1])
        );
    end

    // segment winner, taken with the decode item
    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_win <= link[CELLS];
        end
    end

    assign o_found = link[CELLS].found;
    assign o_win   = r_win;

endmodule

// File: design/prefix_code_table_decoder.sv
// ----------------------------------------------------------------------------
// prefix_code_table_decoder
// Bit-serial prefix-code decoder over a loadable table of code slots.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries load items (req_type 0: write one slot at entry_index) and
//   decode items (req_type 1: one code_bit). o_res carries one item for each
//   decode bit that completes a code (symbol, status 0) or that brings the
//   partial code to MAX_CODE_LEN bits without a match (symbol 0, status 1).
//   Loads and bits that do not complete a code give no result.
// Throughput: one item per cycle while i_req.ready is high; every slot is
//   a cell that matches in the cycle the bit arrives, so the partial code
//   updates with no wait.
// Pipeline: stage 1 registers the winner of each segment of GROUP_SIZE
//   cells; stage 2 picks the lowest-index segment into the output register.
// Stall: while o_res is held, items stay accepted until both pipeline
//   registers are full; then i_req.ready drops.
// Reset: clears every slot's valid flag, the partial code and the pipeline.
//   Slot codes, lengths and symbols are kept until written.
// ----------------------------------------------------------------------------
module prefix_code_table_decoder #(
    parameter int TABLE_DEPTH  = 64,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcd_req_if.sink   i_req,
    pcd_res_if.source o_res
);

    localparam int GS      = pcd_pkg::GROUP_SIZE;
    localparam int NGROUPS = (TABLE_DEPTH + GS - 1) / GS;
    localparam int PLEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CW      = pcd_pkg::CODE_W;

    logic [MAX_CODE_LEN-1:0]   r_pcode;
    logic [PLEN_W-1:0]         r_plen;
    logic [MAX_CODE_LEN-1:0]   n_pcode;
    logic [PLEN_W-1:0]         n_plen;

    logic                      r1_valid;
    logic                      r1_status;
    logic                      r2_valid;
    logic [pcd_pkg::SYM_W-1:0] r2_symbol;
    logic                      r2_status;

    logic                      s1_en;
    logic                      s2_en;
    logic                      accept;
    logic                      load_acc;
    logic                      dec_acc;
    logic                      any_hit;
    logic                      overflow;
    logic                      result;
    logic [pcd_pkg::SYM_W-1:0] pick_symbol;

    logic [CW-1:0]             key_code;
    logic                      key_hi_ok;
    logic [CW-1:0]             key_mask;
    pcd_pkg::t_key             key;
    pcd_pkg::t_slot            wr;
    logic [NGROUPS-1:0]        grp_found;
    pcd_pkg::t_link            grp_win [NGROUPS];

    // handshake
    assign s2_en    = !r2_valid || o_res.ready;
    assign s1_en    = !r1_valid || s2_en;
    assign accept   = i_req.valid && s1_en;
    assign load_acc = accept && (i_req.req_type == pcd_pkg::REQ_LOAD);
    assign dec_acc  = accept && (i_req.req_type == pcd_pkg::REQ_DECODE);

    // partial code with the new bit appended
    assign n_pcode = {r_pcode[MAX_CODE_LEN-2:0], i_req.code_bit};
    assign n_plen  = r_plen + 1'b1;

    // search key
    if (MAX_CODE_LEN > CW) begin : g_key_wide
        assign key_code  = n_pcode[CW-1:0];
        assign key_hi_ok = (n_pcode[MAX_CODE_LEN-1:CW] == '0);
    end else begin : g_key_narrow
        assign key_code  = CW'(n_pcode);
        assign key_hi_ok = 1'b1;
    end

    always_comb begin
        for (int b = 0; b < CW; b++) begin
            key_mask[b] = (pcd_pkg::KEY_LEN_W'(b) < pcd_pkg::KEY_LEN_W'(n_plen));
        end
    end

    assign key = '{length: pcd_pkg::KEY_LEN_W'(n_plen), mask: key_mask,
                   code: key_code, hi_ok: key_hi_ok};

    // slot write data
    assign wr.valid  = i_req.entry_valid;
    assign wr.code   = i_req.entry_code;
    assign wr.length = i_req.entry_length;
    assign wr.symbol = i_req.entry_symbol;

    // cell segments
    for (genvar g = 0; g < NGROUPS; g++) begin : g_group
        localparam int CNT = ((TABLE_DEPTH - g * GS) < GS) ? (TABLE_DEPTH - g * GS) : GS;

        pcd_group #(
            .BASE  (g * GS),
            .CELLS (CNT)
        ) u_group (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_we       (load_acc),
            .i_wr_index (i_req.entry_index),
            .i_wr       (wr),
            .i_key      (key),
            .i_cap      (result),
            .o_found    (grp_found[g]),
            .o_win      (grp_win[g])
        );
    end

    assign any_hit  = |grp_found;
    assign overflow = (n_plen >= PLEN_W'(MAX_CODE_LEN));
    assign result   = dec_acc && (any_hit || overflow);

    // partial code state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcode <= '0;
            r_plen  <= '0;
        end else if (dec_acc) begin
            if (any_hit || overflow) begin
                r_pcode <= '0;
                r_plen  <= '0;
            end else begin
                r_pcode <= n_pcode;
                r_plen  <= n_plen;
            end
        end
    end

    // stage 1: result pending, segment winners held in the groups
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_en) begin
            r1_valid <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result) begin
            r1_status <= any_hit ? pcd_pkg::STAT_SYMBOL : pcd_pkg::STAT_OVERFLOW;
        end
    end

    // lowest segment with a hit; zero when none
    always_comb begin
        pick_symbol = '0;
        for (int g = NGROUPS - 1; g >= 0; g--) begin
            if (grp_win[g].found) begin
                pick_symbol = grp_win[g].symbol;
            end
        end
    end

    // stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en && r1_valid) begin
            r2_symbol <= (r1_status == pcd_pkg::STAT_OVERFLOW) ? '0 : pick_symbol;
            r2_status <= r1_status;
        end
    end

    assign i_req.ready  = s1_en;
    assign o_res.valid  = r2_valid;
    assign o_res.symbol = r2_symbol;
    assign o_res.status = r2_status;

endmodule

// File: design/pcd_checker.sv
// ----------------------------------------------------------------------------
// pcd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "prefix_code_table_decoder_assert.svh"

module pcd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_in_type,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [pcd_pkg::SYM_W-1:0] i_out_symbol,
    input logic                      i_out_status
);

    // a stalled result holds
    `PCD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_symbol) && $stable(i_out_status))

    // overflow carries a zero symbol
    `PCD_ASSERT_IMP(a_ovf_zero, i_clk, i_rst_n, i_out_valid && (i_out_status == pcd_pkg::STAT_OVERFLOW), i_out_symbol == '0)

    // a fresh result follows an accepted decode item through both pipeline registers
    `PCD_ASSERT_IMP(a_res_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready && (i_in_type == pcd_pkg::REQ_DECODE), 2))

    // an empty output never blocks the input
    `PCD_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind prefix_code_table_decoder pcd_checker u_pcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_type    (i_req.req_type),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_symbol (o_res.symbol),
    .i_out_status (o_res.status)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for prefix_code_table_decoder
// Loads code tables and streams code bits through the request channel. Every
// accepted item is run through a local table-and-partial-code predictor.
// Returned symbols and status are matched in order against the predictions.
// A short scripted part covers the corner cases. Random prefix-free tables
// with random decode streams and noise follow. Both channels idle at random,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH  = 64;
    localparam int MAX_CODE_LEN = 16;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_AT      = 600;     // request count that starts the long hold
    localparam int HOLD_CYCLES  = 500;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic                       req_type;
        logic [pcd_pkg::IDX_W-1:0]  entry_index;
        logic [pcd_pkg::CODE_W-1:0] entry_code;
        logic [pcd_pkg::LEN_W-1:0]  entry_length;
        logic [pcd_pkg::SYM_W-1:0]  entry_symbol;
        logic                       entry_valid;
        logic                       code_bit;
    } t_req;

    typedef struct packed {
        logic [pcd_pkg::SYM_W-1:0] symbol;
        logic                      status;
    } t_res;

    localparam int REQ_W = $bits(t_req);

    // how a scripted row is checked
    typedef enum int { CHK_MODEL, CHK_NONE, CHK_RES } t_chk;

    typedef struct {
        t_req item;
        int   reps;
        t_chk mode;
        t_res res;
    } t_row;

    localparam t_res NO_RES = '{symbol: '0, status: pcd_pkg::STAT_SYMBOL};

    logic i_clk;
    logic i_rst_n;

    pcd_req_if req_ch ();
    pcd_res_if res_ch ();

    prefix_code_table_decoder #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // predictor state: code table and partial code
    logic                       tbl_valid [TABLE_DEPTH];
    logic [pcd_pkg::CODE_W-1:0] tbl_code  [TABLE_DEPTH];
    logic [pcd_pkg::LEN_W-1:0]  tbl_len   [TABLE_DEPTH];
    logic [pcd_pkg::SYM_W-1:0]  tbl_sym   [TABLE_DEPTH];
    logic [pcd_pkg::CODE_W-1:0] acc_code;
    int                         acc_len;

    t_res pending_symbols [$];
    int   error_count;
    int   req_count;
    int   res_count;
    int   cycle_count;
    bit   hold_req;
    bit   stall_on;

    t_row script [22];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic t_req load_item(input int idx, input int code, input int len,
                                       input int sym, input logic valid);
        t_req r;
        r.req_type     = pcd_pkg::REQ_LOAD;
        r.entry_index  = pcd_pkg::IDX_W'(idx);
        r.entry_code   = pcd_pkg::CODE_W'(code);
        r.entry_length = pcd_pkg::LEN_W'(len);
        r.entry_symbol = pcd_pkg::SYM_W'(sym);
        r.entry_valid  = valid;
        r.code_bit     = 1'($urandom);      // ignored by a load
        return r;
    endfunction

    function automatic t_req bit_item(input logic b);
        t_req r;
        r              = t_req'(REQ_W'({$urandom, $urandom}));  // entry fields are don't-care
        r.req_type     = pcd_pkg::REQ_DECODE;
        r.code_bit     = b;
        return r;
    endfunction

    function automatic t_req noise_load();
        return load_item($urandom_range(0, TABLE_DEPTH - 1), $urandom,
                         $urandom_range(0, 31), $urandom, 1'($urandom));
    endfunction

    // Apply one item to the local table; returns 1 when a result is due.
    function automatic logic decode_request(input t_req r, output t_res o);
        logic [pcd_pkg::CODE_W:0] span;
        o = NO_RES;
        if (r.req_type == pcd_pkg::REQ_LOAD) begin
            tbl_code[r.entry_index]  = r.entry_code;
            tbl_len[r.entry_index]   = r.entry_length;
            tbl_sym[r.entry_index]   = r.entry_symbol;
            tbl_valid[r.entry_index] = r.entry_valid;
            return 1'b0;
        end
        acc_code = {acc_code[pcd_pkg::CODE_W-2:0], r.code_bit};
        acc_len++;
        span = (pcd_pkg::CODE_W+1)'(1) << acc_len;
        span = span - 1'b1;
        // lowest matching slot wins
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i] && int'(tbl_len[i]) == acc_len &&
                (tbl_code[i] & span[pcd_pkg::CODE_W-1:0]) == acc_code) begin
                o.symbol = tbl_sym[i];
                acc_code = '0;
                acc_len  = 0;
                return 1'b1;
            end
        end
        if (acc_len >= MAX_CODE_LEN) begin
            o.status = pcd_pkg::STAT_OVERFLOW;
            acc_code = '0;
            acc_len  = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one item after a random gap; record the expectation on accept.
    task automatic send_req(input t_req r, input t_chk mode = CHK_MODEL,
                            input t_res typed = NO_RES);
        int   gap;
        t_res pred;
        logic due;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.req_type;
        req_ch.entry_index  <= r.entry_index;
        req_ch.entry_code   <= r.entry_code;
        req_ch.entry_length <= r.entry_length;
        req_ch.entry_symbol <= r.entry_symbol;
        req_ch.entry_valid  <= r.entry_valid;
        req_ch.code_bit     <= r.code_bit;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        due = decode_request(r, pred);
        case (mode)
            CHK_MODEL: begin
                if (due)
                    pending_symbols.insert(pending_symbols.size(), pred);
            end
            CHK_RES: begin
                pending_symbols.insert(pending_symbols.size(), typed);
            end
            default: ;
        endcase
        req_count++;
        if (req_count == HOLD_AT)
            hold_req = 1'b1;
        @(negedge i_clk);
    endtask

    // One random prefix-free table, then a stream of its codes with noise.
    task automatic run_episode();
        int lf_code [$];
        int lf_len  [$];
        bit used [TABLE_DEPTH];
        int n_leaves, tries, pick, deep_pct, slot, c, l, n_syms;
        // retire what the last table left active
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i])
                send_req(load_item(i, $urandom, $urandom_range(0, 31), $urandom, 1'b0));
        // grow a code tree by splitting leaves
        lf_code.insert(lf_code.size(), 0);
        lf_len.insert(lf_len.size(), 0);
        n_leaves = $urandom_range(2, 24);
        deep_pct = ($urandom_range(0, 4) == 0) ? 80 : 25;
        tries    = 0;
        while (lf_code.size() < n_leaves && tries < 300) begin
            tries++;
            pick = $urandom_range(0, lf_code.size() - 1);
            if ($urandom_range(0, 99) < deep_pct)
                foreach (lf_len[k])
                    if (lf_len[k] > lf_len[pick])
                        pick = k;
            if (lf_len[pick] < MAX_CODE_LEN) begin
                c = lf_code[pick];
                l = lf_len[pick];
                lf_code[pick] = c << 1;
                lf_len[pick]  = l + 1;
                lf_code.insert(lf_code.size(), (c << 1) | 1);
                lf_len.insert(lf_len.size(), l + 1);
            end
        end
        // load leaves at random slots, garbage above the code, a few holes
        foreach (lf_code[k]) begin
            if ($urandom_range(0, 9) != 0) begin
                do slot = $urandom_range(0, TABLE_DEPTH - 1); while (used[slot]);
                used[slot] = 1'b1;
                c = ($urandom & ~((1 << lf_len[k]) - 1)) | lf_code[k];
                send_req(load_item(slot, c, lf_len[k], $urandom, 1'b1));
            end
        end
        repeat ($urandom_range(0, 3))
            send_req(noise_load());
        // decode stream
        n_syms = $urandom_range(4, 40);
        repeat (n_syms) begin
            case ($urandom_range(0, 19))
                0: begin
                    repeat ($urandom_range(1, 20))
                        send_req(bit_item(1'($urandom)));
                end
                1: begin
                    send_req(noise_load());
                end
                default: begin
                    pick = $urandom_range(0, lf_code.size() - 1);
                    c    = lf_code[pick];
                    for (int b = lf_len[pick] - 1; b >= 0; b--)
                        send_req(bit_item(c[b]));
                end
            endcase
        end
    endtask

    // long result-side hold, counted here
    initial begin
        stall_on = 1'b0;
        wait (hold_req);
        stall_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        stall_on = 1'b0;
    end

    // result side: random ready gaps, in-order compare
    initial begin : receiver
        int   wait_cycles;
        t_res want;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            wait_cycles = $urandom_range(0, 9);
            if (wait_cycles > 0 || stall_on) begin
                res_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
                while (stall_on) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            res_count++;
            if (pending_symbols.size() == 0) begin
                report_mismatch($sformatf("unexpected result symbol %0h status %0b",
                                          res_ch.symbol, res_ch.status));
            end else begin
                want = pending_symbols.pop_front();
                if (res_ch.symbol !== want.symbol)
                    report_mismatch($sformatf("result %0d symbol %0h, want %0h",
                                              res_count, res_ch.symbol, want.symbol));
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0b, want %0b",
                                              res_count, res_ch.status, want.status));
            end
            @(negedge i_clk);
        end
    end

    // reset, scripted part, random part, drain
    initial begin
        int start_count;
        error_count         = 0;
        req_count           = 0;
        res_count           = 0;
        cycle_count         = 0;
        hold_req            = 1'b0;
        acc_code            = '0;
        acc_len             = 0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = pcd_pkg::REQ_LOAD;
        req_ch.entry_index  = '0;
        req_ch.entry_code   = '0;
        req_ch.entry_length = '0;
        req_ch.entry_symbol = '0;
        req_ch.entry_valid  = 1'b0;
        req_ch.code_bit     = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_code[i]  = '0;
            tbl_len[i]   = '0;
            tbl_sym[i]   = '0;
        end

        script = '{
            // empty table: bits run into an overflow
            '{bit_item(1'b1), 15, CHK_NONE, NO_RES},
            '{bit_item(1'b0), 1,  CHK_RES,  '{8'h00, pcd_pkg::STAT_OVERFLOW}},
            '{load_item(0, 16'h0000, 1, 8'hA5, 1'b1), 1, CHK_NONE, NO_RES},
            '{bit_item(1'b0), 1,  CHK_RES,  '{8'hA5, pcd_pkg::STAT_SYMBOL}},
            // full-length code wins over the overflow
            '{load_item(63, 16'hFFFF, 16, 8'hFF, 1'b1), 1, CHK_NONE, NO_RES},
            '{bit_item(1'b1), 15, CHK_NONE, NO_RES},
            '{bit_item(1'b1), 1,  CHK_RES,  '{8'hFF, pcd_pkg::STAT_SYMBOL}},
            // bits above the length are ignored
            '{load_item(1, 16'hFFFF, 1, 8'h00, 1'b1), 1, CHK_NONE, NO_RES},
            '{bit_item(1'b1), 1,  CHK_RES,  '{8'h00, pcd_pkg::STAT_SYMBOL}},
            // invalidated slot drops out, lowest remaining index wins
            '{load_item(3, 16'h0000, 1, 8'h33, 1'b1), 1, CHK_NONE, NO_RES},
            '{load_item(2, 16'h0000, 1, 8'h22, 1'b1), 1, CHK_NONE, NO_RES},
            '{load_item(0, 16'h0000, 1, 8'h11, 1'b0), 1, CHK_NONE, NO_RES},
            '{bit_item(1'b0), 1,  CHK_RES,  '{8'h22, pcd_pkg::STAT_SYMBOL}},
            '{load_item(1, 16'h0001, 1, 8'h00, 1'b0), 1, CHK_NONE, NO_RES},
            // lengths zero and above the maximum never match
            '{load_item(4, 16'h0002, 0,  8'h44, 1'b1), 1, CHK_NONE, NO_RES},
            '{load_item(5, 16'h0002, 31, 8'h55, 1'b1), 1, CHK_NONE, NO_RES},
            '{load_item(6, 16'h0002, 17, 8'h66, 1'b1), 1, CHK_NONE, NO_RES},
            '{load_item(7, 16'hFFFE, 2,  8'h77, 1'b1), 1, CHK_NONE, NO_RES},
            // a load in the middle of a code leaves the partial code alone
            '{bit_item(1'b1), 1,  CHK_NONE, NO_RES},
            '{load_item(8, 16'h5A5A, 8, 8'h5A, 1'b1), 1, CHK_NONE, NO_RES},
            '{bit_item(1'b0), 1,  CHK_RES,  '{8'h77, pcd_pkg::STAT_SYMBOL}},
            '{bit_item(1'b0), 7,  CHK_MODEL, NO_RES}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[k])
            repeat (script[k].reps)
                send_req(script[k].item, script[k].mode, script[k].res);

        start_count = req_count;
        while (req_count - start_count < RANDOM_ITEMS)
            run_episode();
        req_ch.valid <= 1'b0;

        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_symbols.size() != 0)
            report_mismatch("expected result never arrived");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/pcd_pkg.sv
design/pcd_if.sv
design/pcd_cell.sv
design/pcd_group.sv
design/prefix_code_table_decoder.sv
design/pcd_checker.sv
test/testbench.sv
